>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types for the truncated causal convolution block: commands from the
// controller to the datapath and status back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcc_pkg;

    // Width of the sample and result ports
    localparam int PORT_W = 32;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // take the input beat, store it, clear the sum
        logic step;     // read one product pair and advance k
        logic emit;     // load the result register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic idx_full;   // index has reached MAX_LEN
        logic k_done;     // the pair being read is the last of this term
        logic pipe_busy;  // products still on their way to the sum
        logic out_free;   // result register can take a new beat
    } t_status;

endpackage

>>> hdl/truncated_causal_convolution.sv
// ----------------------------------------------------------------------------
// truncated_causal_convolution: term j of a causal convolution, one MAC.
// An input beat is stored, the pairs are read, multiplied and summed, and the result
// is registered; no new input is taken until that result is handed off.
// Reset (synchronous, active low) clears the index, control state and valid flags only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module truncated_causal_convolution
    import tcc_pkg::*;
#(
    parameter int MAX_LEN     = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [PORT_W-1:0] i_a_sample,
    input  logic [PORT_W-1:0] i_b_sample,
    input  logic              i_last,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [PORT_W-1:0] o_conv_value,
    output logic              o_saturated,
    output logic              o_overflow,
    output logic              o_last_out
);

    localparam int USED_W = (SAMPLE_BITS < PORT_W) ? SAMPLE_BITS : PORT_W;

    t_cmd    w_cmd;
    t_status w_status;

    tcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    tcc_datapath #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_a_sample   (i_a_sample),
        .i_b_sample   (i_b_sample),
        .i_last       (i_last),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_conv_value (o_conv_value),
        .o_saturated  (o_saturated),
        .o_overflow   (o_overflow),
        .o_last_out   (o_last_out)
    );

    // An overflowing beat carries a zero value and no clamp
    `ASSERT_IMP(a_ovf_zero, o_out_valid && o_overflow, (o_conv_value == '0) && !o_saturated, "overflow beat with nonzero value")
    // A clamped beat carries all ones in the used sample bits
    `ASSERT_IMP(a_sat_ones, o_out_valid && o_saturated, o_conv_value == PORT_W'({USED_W{1'b1}}), "saturated beat not all ones")
    // One input beat at a time: busy right after an accept
    `ASSERT_NXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "input not stalled after accept")

endmodule

>>> hdl/tcc_ctrl.sv
// ----------------------------------------------------------------------------
// tcc_ctrl
// Sequencer: takes one input beat, steps the multiply-accumulate through the
// stored samples, waits for the pipeline to drain and hands off the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcc_ctrl
    import tcc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // Decode commands and next state
    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.emit   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    // an index past the end skips the sum altogether
                    n_state = i_status.idx_full ? S_DRAIN : S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_status.k_done) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy && i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

>>> hdl/tcc_datapath.sv
// ----------------------------------------------------------------------------
// tcc_datapath
// Sample stores, index and term counters, one multiplier feeding a wide
// accumulator, and the truncate/saturate stage with the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcc_datapath
    import tcc_pkg::*;
#(
    parameter int MAX_LEN     = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic [PORT_W-1:0] i_a_sample,
    input  logic [PORT_W-1:0] i_b_sample,
    input  logic              i_last,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [PORT_W-1:0] o_conv_value,
    output logic              o_saturated,
    output logic              o_overflow,
    output logic              o_last_out
);

    localparam int USED_W = (SAMPLE_BITS < PORT_W) ? SAMPLE_BITS : PORT_W;
    localparam int IDX_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int PROD_W = 2 * USED_W;
    localparam int ACC_W  = PROD_W + IDX_W;

    // Sample stores
    logic [USED_W-1:0] r_mem_a [MAX_LEN];
    logic [USED_W-1:0] r_mem_b [MAX_LEN];

    logic [IDX_W-1:0]  r_next_index;
    logic [IDX_W-1:0]  n_next_index;
    logic [ADDR_W-1:0] r_cur_j;
    logic [ADDR_W-1:0] r_k;
    logic              r_ovf;
    logic              r_last;

    logic [USED_W-1:0] r_rd_a;
    logic [USED_W-1:0] r_rd_b;
    logic              r_rd_v;
    logic [PROD_W-1:0] r_prod;
    logic              r_prod_v;
    logic [ACC_W-1:0]  r_acc;

    logic              w_full;
    logic [ACC_W-1:0]  w_shift;
    logic [PORT_W-1:0] w_value;
    logic              w_sat;

    assign w_full = (r_next_index >= IDX_W'(MAX_LEN));

    // Advance the index: clear on last, hold at the end
    always_comb begin
        n_next_index = r_next_index;
        if (i_cmd.accept) begin
            if (i_last) begin
                n_next_index = '0;
            end else if (!w_full) begin
                n_next_index = r_next_index + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_index <= '0;
        end else begin
            r_next_index <= n_next_index;
        end
    end

    // Write the new pair at the current index
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !w_full) begin
            r_mem_a[r_next_index[ADDR_W-1:0]] <= i_a_sample[USED_W-1:0];
            r_mem_b[r_next_index[ADDR_W-1:0]] <= i_b_sample[USED_W-1:0];
        end
    end

    // Read a[k] and b[j-k]
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_rd_a <= r_mem_a[r_k];
            r_rd_b <= r_mem_b[r_cur_j - r_k];
        end
    end

    // Latch the item and walk k over the term
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur_j <= r_next_index[ADDR_W-1:0];
            r_k     <= '0;
            r_ovf   <= w_full;
            r_last  <= i_last;
        end else if (i_cmd.step) begin
            r_k <= r_k + 1'b1;
        end
    end

    // Multiply, then accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= r_rd_a * r_rd_b;
        if (i_cmd.accept) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
        end else begin
            r_rd_v   <= i_cmd.step;
            r_prod_v <= r_rd_v;
        end
    end

    // Truncate to the sample fraction and clamp at all ones
    assign w_shift = r_acc >> SAMPLE_BITS;
    assign w_sat   = ((w_shift >> USED_W) != '0);
    assign w_value = w_sat ? PORT_W'({USED_W{1'b1}}) : PORT_W'(w_shift[USED_W-1:0]);

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_conv_value <= r_ovf ? '0 : w_value;
            o_saturated  <= !r_ovf && w_sat;
            o_overflow   <= r_ovf;
            o_last_out   <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    assign o_status.idx_full  = w_full;
    assign o_status.k_done    = (r_k == r_cur_j);
    assign o_status.pipe_busy = r_rd_v || r_prod_v;
    assign o_status.out_free  = !o_out_valid || !i_out_stall;

endmodule
